// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared sizes, codes and the cell record of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OpWidth     = 2;
  localparam int ItemDWidth  = 32;
  localparam int PrioWidth   = 16;
  localparam int StatusWidth = 2;
  localparam int CountOWidth = 5;
  localparam int CountWidth  = $clog2(DEPTH + 1);

  localparam logic [OpWidth-1:0] OP_PUSH = 2'd0;
  localparam logic [OpWidth-1:0] OP_POP  = 2'd1;
  localparam logic [OpWidth-1:0] OP_PEEK = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cmd_e;

  typedef struct packed {
    logic                        valid;
    logic signed [PrioWidth-1:0] prio;
    logic [DATA_WIDTH-1:0]       data;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, shifts right on insert, shifts left on pop
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spq_pkg::cmd_e   cmd_i,
  input  wire spq_pkg::entry_t new_i,
  input  wire spq_pkg::entry_t left_i,
  input  wire logic            left_ge_i,
  input  wire spq_pkg::entry_t right_i,
  output spq_pkg::entry_t      entry_o,
  output logic                 ge_o
);
  import spq_pkg::*;

  logic                        valid_q, valid_d;
  logic signed [PrioWidth-1:0] prio_q, prio_d;
  logic [DATA_WIDTH-1:0]       data_q, data_d;
  entry_t                      sel;

  // stored entry stays ahead of the new one when its priority is equal or higher
  assign ge_o = valid_q && (prio_q >= new_i.prio);

  always_comb begin
    sel = '{valid: valid_q, prio: prio_q, data: data_q};
    case (cmd_i)
      CMD_PUSH: begin
        if (!ge_o) begin
          sel = left_ge_i ? new_i : left_i;
        end
      end
      CMD_POP: begin
        sel = right_i;
      end
      default: begin
        sel = '{valid: valid_q, prio: prio_q, data: data_q};
      end
    endcase
    valid_d = sel.valid;
    prio_d  = sel.prio;
    data_d  = sel.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign entry_o = '{valid: valid_q, prio: prio_q, data: data_q};

endmodule
`default_nettype wire

// ===== hw/rtl/stable_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue held in a sorted chain of cells, oldest first on ties
// ----------------------------------------------------------------------------
// usage
//   command beat: op_i, item_data_i and item_priority_i are taken at a rising
//   edge with start_i high and busy_o low. busy_o stays low: every cell does
//   its compare and shift in the same cycle, so a beat may follow each cycle.
//   result beat: status_o, head_data_o and count_o show in the cycle after the
//   command, marked by done_o for exactly one cycle. the receiver cannot stall
//   the queue, so a result is offered once and never held.
//   throughput 1 command per cycle, as every cell does its insert or remove
//   in the same cycle as the command beat.
//   push into a full queue is dropped with status full; pop or peek on an
//   empty queue returns status empty and zero data. op code three does nothing.
//   reset clears the valid bit of every cell and the count; entry payloads
//   are left as they are and never read while invalid.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] item_data_i,
  input  wire logic signed [15:0] item_priority_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [31:0]      head_data_o,
  output logic [4:0]       count_o
);
  import spq_pkg::*;

  localparam logic [CountWidth-1:0] DepthC = CountWidth'(DEPTH);

  // chain wiring: index 0 is the head
  entry_t      cells [DEPTH];
  logic        ge    [DEPTH];
  entry_t      new_entry;
  entry_t      empty_entry;
  cmd_e        cmd;

  logic [CountWidth-1:0] count_q, count_d;
  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic [31:0]           head_q, head_d;

  logic full, empty;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  assign new_entry   = '{valid: 1'b1, prio: item_priority_i,
                         data: DATA_WIDTH'(item_data_i)};
  assign empty_entry = '{valid: 1'b0, prio: '0, data: '0};

  // decode the command beat into what the row of cells does this cycle
  always_comb begin
    cmd      = CMD_HOLD;
    count_d  = count_q;
    status_d = ST_OK;
    head_d   = '0;
    done_d   = 1'b0;
    if (start_i) begin
      done_d = 1'b1;
      case (op_i)
        OP_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd     = CMD_PUSH;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd     = CMD_POP;
            head_d  = 32'(cells[0].data);
            count_d = count_q - 1'b1;
          end
        end
        OP_PEEK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            head_d = 32'(cells[0].data);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // row of cells; the head sees the new entry as its left neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_ge;
    if (i == 0) begin : g_head
      assign left_e  = new_entry;
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left_e  = cells[i-1];
      assign left_ge = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = empty_entry;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .new_i     (new_entry),
      .left_i    (left_e),
      .left_ge_i (left_ge),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .ge_o      (ge[i])
    );
  end

  // count and result beat registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    head_q   <= head_d;
  end

  assign busy_o      = 1'b0;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign head_data_o = head_q;
  // count after the operation, shown with the result
  assign count_o     = CountOWidth'(count_q);

endmodule
`default_nettype wire
